// ----- hw/rtl/bw_pkg.sv -----
// shared widths, word types and helper functions for the barycentric weights block
// no dependencies; imported by every module of the block
package bw_pkg;

    localparam int COORD_WIDTH      = 20;
    localparam int WEIGHT_WIDTH     = 24;
    localparam int WEIGHT_FRAC_BITS = 16;

    // widths of the exact integer datapath
    localparam int DIFF_W   = COORD_WIDTH + 1;
    localparam int PROD_W   = 2 * DIFF_W;
    localparam int CROSS_W  = PROD_W + 1;
    localparam int SPLIT_LO = CROSS_W / 2;
    localparam int SPLIT_HI = CROSS_W - SPLIT_LO;
    localparam int DOT_W    = 2 * CROSS_W;
    localparam int NUM_W    = DOT_W + 2;
    localparam int DEN_W    = DOT_W;

    // quotient magnitude stays below 2^QUOT_BITS before rounding, else capped at that value
    localparam int QUOT_BITS = 61;
    localparam int QMAG_W    = QUOT_BITS + 1;
    localparam int WSUM_W    = QMAG_W + 3;

    localparam int W_MAX = (2 ** (WEIGHT_WIDTH - 1)) - 1;
    localparam int W_MIN = -(2 ** (WEIGHT_WIDTH - 1));

    typedef logic signed [COORD_WIDTH-1:0]  coord_t;
    typedef logic signed [WEIGHT_WIDTH-1:0] weight_t;
    typedef logic signed [DIFF_W-1:0]       diff_t;
    typedef logic signed [PROD_W-1:0]       prod_t;
    typedef logic signed [CROSS_W-1:0]      cross_t;
    typedef logic signed [DOT_W-1:0]        dot_t;
    typedef logic signed [NUM_W-1:0]        num_t;
    typedef logic signed [QMAG_W:0]         sq_t;
    typedef logic signed [WSUM_W-1:0]       wsum_t;

    typedef struct packed {
        coord_t vertex_a_x;
        coord_t vertex_a_y;
        coord_t vertex_a_z;
        coord_t vertex_b_x;
        coord_t vertex_b_y;
        coord_t vertex_b_z;
        coord_t vertex_c_x;
        coord_t vertex_c_y;
        coord_t vertex_c_z;
        coord_t query_x;
        coord_t query_y;
        coord_t query_z;
    } query_t;

    typedef struct packed {
        weight_t weight_a;
        weight_t weight_b;
        weight_t weight_c;
        logic    degenerate;
        logic    saturated;
    } weights_t;

    typedef struct packed {
        diff_t x;
        diff_t y;
        diff_t z;
    } dvec_t;

    typedef struct packed {
        cross_t x;
        cross_t y;
        cross_t z;
    } cvec_t;

    // normal and the two point cross products
    typedef struct packed {
        cvec_t n;
        cvec_t u;
        cvec_t v;
    } cross_set_t;

    // sideband that rides along a divider lane
    typedef struct packed {
        logic neg;
        logic degen;
    } div_tag_t;

    typedef struct packed {
        weight_t w;
        logic    sat;
    } clip_t;

    // dividend width after the fraction shift, at least one bit above the quotient
    function automatic int mag_pad_w(input int frac);
        int mw;
        mw = NUM_W - 1 + frac;
        return (mw > QUOT_BITS) ? mw : QUOT_BITS + 1;
    endfunction

    function automatic clip_t clip_weight(input wsum_t x);
        clip_t r;
        if (x > wsum_t'(W_MAX))
        begin
            r.w   = weight_t'(W_MAX);
            r.sat = 1'b1;
        end
        else if (x < wsum_t'(W_MIN))
        begin
            r.w   = weight_t'(W_MIN);
            r.sat = 1'b1;
        end
        else
        begin
            r.w   = weight_t'(x);
            r.sat = 1'b0;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/bw_front.sv -----
// front end: edge vectors, cross product terms and cross products, three stages
// depends on bw_pkg
module bw_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  bw_pkg::query_t      query,
    output logic                out_valid,
    output bw_pkg::cross_set_t  cross_set
);
    import bw_pkg::*;

    logic       v1_reg, v2_reg, v3_reg;
    dvec_t      lhs_reg [3];
    dvec_t      rhs_reg [3];
    dvec_t      lhs_next [3];
    dvec_t      rhs_next [3];
    prod_t      prod_reg [18];
    prod_t      prod_next [18];
    cvec_t      cr_next [3];
    cross_set_t cross_reg;

    // edges c1 = b - a, c2 = c - a, q = p - a
    always_comb
    begin
        dvec_t c1, c2, q;
        c1.x = diff_t'(query.vertex_b_x) - diff_t'(query.vertex_a_x);
        c1.y = diff_t'(query.vertex_b_y) - diff_t'(query.vertex_a_y);
        c1.z = diff_t'(query.vertex_b_z) - diff_t'(query.vertex_a_z);
        c2.x = diff_t'(query.vertex_c_x) - diff_t'(query.vertex_a_x);
        c2.y = diff_t'(query.vertex_c_y) - diff_t'(query.vertex_a_y);
        c2.z = diff_t'(query.vertex_c_z) - diff_t'(query.vertex_a_z);
        q.x  = diff_t'(query.query_x) - diff_t'(query.vertex_a_x);
        q.y  = diff_t'(query.query_y) - diff_t'(query.vertex_a_y);
        q.z  = diff_t'(query.query_z) - diff_t'(query.vertex_a_z);
        // n = c1 x c2, u = c2 x q, v = c1 x q
        lhs_next[0] = c1;
        rhs_next[0] = c2;
        lhs_next[1] = c2;
        rhs_next[1] = q;
        lhs_next[2] = c1;
        rhs_next[2] = q;
    end

    always_comb
    begin
        for (int m = 0; m < 3; m++)
        begin
            prod_next[6*m+0] = lhs_reg[m].y * rhs_reg[m].z;
            prod_next[6*m+1] = lhs_reg[m].z * rhs_reg[m].y;
            prod_next[6*m+2] = lhs_reg[m].z * rhs_reg[m].x;
            prod_next[6*m+3] = lhs_reg[m].x * rhs_reg[m].z;
            prod_next[6*m+4] = lhs_reg[m].x * rhs_reg[m].y;
            prod_next[6*m+5] = lhs_reg[m].y * rhs_reg[m].x;
        end
    end

    always_comb
    begin
        for (int m = 0; m < 3; m++)
        begin
            cr_next[m].x = cross_t'(prod_reg[6*m+0]) - cross_t'(prod_reg[6*m+1]);
            cr_next[m].y = cross_t'(prod_reg[6*m+2]) - cross_t'(prod_reg[6*m+3]);
            cr_next[m].z = cross_t'(prod_reg[6*m+4]) - cross_t'(prod_reg[6*m+5]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            lhs_reg     <= lhs_next;
            rhs_reg     <= rhs_next;
            prod_reg    <= prod_next;
            cross_reg.n <= cr_next[0];
            cross_reg.u <= cr_next[1];
            cross_reg.v <= cr_next[2];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign cross_set = cross_reg;

endmodule

// ----- hw/rtl/bw_dot.sv -----
// dot products n.n, u.n, v.n from split partial products, then sign and magnitude
// depends on bw_pkg
module bw_dot #(
    parameter int WEIGHT_FRAC_BITS = bw_pkg::WEIGHT_FRAC_BITS
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            en,
    input  logic                                            in_valid,
    input  bw_pkg::cross_set_t                              cross_set,
    output logic                                            out_valid,
    output logic [bw_pkg::mag_pad_w(WEIGHT_FRAC_BITS)-1:0]  mag_b,
    output logic [bw_pkg::mag_pad_w(WEIGHT_FRAC_BITS)-1:0]  mag_c,
    output logic [bw_pkg::DEN_W-1:0]                        den,
    output bw_pkg::div_tag_t                                tag_b,
    output bw_pkg::div_tag_t                                tag_c
);
    import bw_pkg::*;

    localparam int MAGP  = mag_pad_w(WEIGHT_FRAC_BITS);
    localparam int NPROD = 9;

    typedef logic signed [2*SPLIT_HI-1:0]        hh_t;
    typedef logic signed [SPLIT_HI+SPLIT_LO:0]   hl_t;
    typedef logic        [2*SPLIT_LO-1:0]        ll_t;

    cross_t           opa [NPROD];
    cross_t           opb [NPROD];
    hh_t              hh_reg [NPROD];
    hl_t              hl_reg [NPROD];
    hl_t              lh_reg [NPROD];
    ll_t              ll_reg [NPROD];
    dot_t             prod_reg [NPROD];
    logic [DEN_W-1:0] den3_reg, den4_reg;
    num_t             sum_u_reg, sum_v_reg;
    num_t             sum_u_next, sum_v_next, den_sum;
    logic [NUM_W-1:0] abs_u, abs_v;
    logic [MAGP-1:0]  mag_b_reg, mag_c_reg;
    div_tag_t         tag_b_reg, tag_c_reg;
    logic             v1_reg, v2_reg, v3_reg, v4_reg;

    always_comb
    begin
        opa[0] = cross_set.n.x;
        opa[1] = cross_set.n.y;
        opa[2] = cross_set.n.z;
        opa[3] = cross_set.u.x;
        opa[4] = cross_set.u.y;
        opa[5] = cross_set.u.z;
        opa[6] = cross_set.v.x;
        opa[7] = cross_set.v.y;
        opa[8] = cross_set.v.z;
        for (int k = 0; k < NPROD; k++)
        begin
            unique case (k % 3)
                0:       opb[k] = cross_set.n.x;
                1:       opb[k] = cross_set.n.y;
                default: opb[k] = cross_set.n.z;
            endcase
        end
    end

    // each wide product as four narrow partial products, recombined a stage later
    for (genvar k = 0; k < NPROD; k++)
    begin : g_prod
        hh_t  hh_next;
        hl_t  hl_next, lh_next;
        ll_t  ll_next;
        dot_t prod_next;

        assign hh_next = $signed(opa[k][CROSS_W-1:SPLIT_LO])
                       * $signed(opb[k][CROSS_W-1:SPLIT_LO]);
        assign hl_next = $signed(opa[k][CROSS_W-1:SPLIT_LO])
                       * $signed({1'b0, opb[k][SPLIT_LO-1:0]});
        assign lh_next = $signed({1'b0, opa[k][SPLIT_LO-1:0]})
                       * $signed(opb[k][CROSS_W-1:SPLIT_LO]);
        assign ll_next = opa[k][SPLIT_LO-1:0] * opb[k][SPLIT_LO-1:0];

        assign prod_next = (dot_t'(hh_reg[k]) <<< (2 * SPLIT_LO))
                         + ((dot_t'(hl_reg[k]) + dot_t'(lh_reg[k])) <<< SPLIT_LO)
                         + dot_t'(ll_reg[k]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                hh_reg[k]   <= hh_next;
                hl_reg[k]   <= hl_next;
                lh_reg[k]   <= lh_next;
                ll_reg[k]   <= ll_next;
                prod_reg[k] <= prod_next;
            end
        end
    end

    always_comb
    begin
        den_sum    = num_t'(prod_reg[0]) + num_t'(prod_reg[1]) + num_t'(prod_reg[2]);
        sum_u_next = num_t'(prod_reg[3]) + num_t'(prod_reg[4]) + num_t'(prod_reg[5]);
        sum_v_next = num_t'(prod_reg[6]) + num_t'(prod_reg[7]) + num_t'(prod_reg[8]);
        abs_u      = sum_u_reg[NUM_W-1] ? NUM_W'(-sum_u_reg) : NUM_W'(sum_u_reg);
        abs_v      = sum_v_reg[NUM_W-1] ? NUM_W'(-sum_v_reg) : NUM_W'(sum_v_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den3_reg  <= den_sum[DEN_W-1:0];
            sum_u_reg <= sum_u_next;
            sum_v_reg <= sum_v_next;
            den4_reg  <= den3_reg;
            mag_b_reg <= MAGP'(abs_u[NUM_W-2:0]) << WEIGHT_FRAC_BITS;
            mag_c_reg <= MAGP'(abs_v[NUM_W-2:0]) << WEIGHT_FRAC_BITS;
            // weight b takes the negated sum
            tag_b_reg.neg   <= !sum_u_reg[NUM_W-1];
            tag_c_reg.neg   <= sum_v_reg[NUM_W-1];
            tag_b_reg.degen <= (den3_reg == '0);
            tag_c_reg.degen <= (den3_reg == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign mag_b     = mag_b_reg;
    assign mag_c     = mag_c_reg;
    assign den       = den4_reg;
    assign tag_b     = tag_b_reg;
    assign tag_c     = tag_c_reg;

endmodule

// ----- hw/rtl/bw_div.sv -----
// pipelined restoring divider lane: range check, one quotient bit a stage, rounding
// depends on bw_pkg
module bw_div #(
    parameter int WEIGHT_FRAC_BITS = bw_pkg::WEIGHT_FRAC_BITS
) (
    input  logic                                            clk,
    input  logic                                            rst_n,
    input  logic                                            en,
    input  logic                                            in_valid,
    input  logic [bw_pkg::mag_pad_w(WEIGHT_FRAC_BITS)-1:0]  mag,
    input  logic [bw_pkg::DEN_W-1:0]                        den,
    input  bw_pkg::div_tag_t                                tag_in,
    output logic                                            out_valid,
    output logic [bw_pkg::QMAG_W-1:0]                       quot,
    output bw_pkg::div_tag_t                                tag_out
);
    import bw_pkg::*;

    localparam int MAGP  = mag_pad_w(WEIGHT_FRAC_BITS);
    localparam int HI_W  = MAGP - QUOT_BITS;
    localparam int CMP_W = (HI_W > DEN_W) ? HI_W : DEN_W;

    logic [DEN_W-1:0]     rem_reg [QUOT_BITS+1];
    logic [DEN_W-1:0]     den_reg [QUOT_BITS+1];
    logic [QUOT_BITS-1:0] lo_reg  [QUOT_BITS+1];
    logic                 cap_reg [QUOT_BITS+1];
    div_tag_t             tag_reg [QUOT_BITS+1];
    logic                 vld_reg [QUOT_BITS+1];

    logic [CMP_W-1:0]     hi_ext, den_ext;
    logic                 cap_next;
    logic [DEN_W-1:0]     rem0_next;
    logic                 round_up;
    logic [QMAG_W-1:0]    quot_next, quot_reg;
    div_tag_t             tag_out_reg;
    logic                 vld_out_reg;

    // quotient at or above the cap when the top dividend bits already reach den
    always_comb
    begin
        hi_ext    = CMP_W'(mag[MAGP-1:QUOT_BITS]);
        den_ext   = CMP_W'(den);
        cap_next  = (hi_ext >= den_ext);
        rem0_next = cap_next ? '0 : hi_ext[DEN_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0] <= rem0_next;
            den_reg[0] <= den;
            lo_reg[0]  <= mag[QUOT_BITS-1:0];
            cap_reg[0] <= cap_next;
            tag_reg[0] <= tag_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg[0] <= 1'b0;
        else if (en)
            vld_reg[0] <= in_valid;
    end

    for (genvar s = 1; s <= QUOT_BITS; s++)
    begin : g_step
        logic [DEN_W:0]       trial;
        logic                 ge;
        logic [DEN_W-1:0]     rem_next;
        logic [QUOT_BITS-1:0] lo_next;

        assign trial    = {rem_reg[s-1], lo_reg[s-1][QUOT_BITS-1]};
        assign ge       = (trial >= {1'b0, den_reg[s-1]});
        assign rem_next = ge ? DEN_W'(trial - {1'b0, den_reg[s-1]}) : trial[DEN_W-1:0];
        // dividend bits shift out at the top as quotient bits enter at the bottom
        assign lo_next  = {lo_reg[s-1][QUOT_BITS-2:0], ge};

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[s] <= rem_next;
                den_reg[s] <= den_reg[s-1];
                lo_reg[s]  <= lo_next;
                cap_reg[s] <= cap_reg[s-1];
                tag_reg[s] <= tag_reg[s-1];
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                vld_reg[s] <= 1'b0;
            else if (en)
                vld_reg[s] <= vld_reg[s-1];
        end
    end

    // round to nearest, ties away from zero, on the magnitude
    always_comb
    begin
        round_up = ({rem_reg[QUOT_BITS], 1'b0} >= {1'b0, den_reg[QUOT_BITS]});
        if (cap_reg[QUOT_BITS])
            quot_next = QMAG_W'(1) << QUOT_BITS;
        else
            quot_next = QMAG_W'(lo_reg[QUOT_BITS]) + QMAG_W'(round_up);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quot_reg    <= quot_next;
            tag_out_reg <= tag_reg[QUOT_BITS];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_out_reg <= 1'b0;
        else if (en)
            vld_out_reg <= vld_reg[QUOT_BITS];
    end

    assign out_valid = vld_out_reg;
    assign quot      = quot_reg;
    assign tag_out   = tag_out_reg;

endmodule

// ----- hw/rtl/triangle_barycentric_weights_top.sv -----
// a query word passes front end, dot stages, divider lanes, sign stage and output register
// throughput: one query word per cycle; every stage moves together, a stall holds them all
// the length is set by the divider lanes, which resolve one quotient bit per stage
// reset (rst_n, asynchronous, active low) clears only the valid bits; the datapath is free
// depends on bw_pkg, bw_front, bw_dot and bw_div
module triangle_barycentric_weights_top #(
    parameter int WEIGHT_FRAC_BITS = bw_pkg::WEIGHT_FRAC_BITS
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             query_valid,
    output logic             query_ready,
    input  bw_pkg::query_t   query,
    output logic             weights_valid,
    input  logic             weights_ready,
    output bw_pkg::weights_t weights
);
    import bw_pkg::*;

    localparam int    MAGP = mag_pad_w(WEIGHT_FRAC_BITS);
    localparam wsum_t ONE  = wsum_t'(1) <<< WEIGHT_FRAC_BITS;

    // global advance: the pipe moves whenever the output register is free or being taken
    logic             en;

    // front end to dot product stages
    logic             front_valid;
    cross_set_t       cross_set;

    // dot product stages to divider lanes
    logic             dot_valid;
    logic [MAGP-1:0]  mag_b, mag_c;
    logic [DEN_W-1:0] den;
    div_tag_t         dtag_b, dtag_c;

    // divider lane outputs
    logic              div_b_valid, div_c_valid;
    logic [QMAG_W-1:0] quot_b, quot_c;
    div_tag_t          tag_b, tag_c;

    // signed quotient stage
    logic             t1_valid_reg;
    sq_t              wb_reg, wc_reg;
    sq_t              wb_next, wc_next;
    logic             degen_reg;

    // output register
    logic             weights_valid_reg;
    weights_t         weights_reg, weights_next;
    wsum_t            wa_sum;
    clip_t            ca, cb, cc;

    assign en          = !weights_valid_reg || weights_ready;
    assign query_ready = en;

    bw_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (query_valid),
        .query     (query),
        .out_valid (front_valid),
        .cross_set (cross_set)
    );

    bw_dot #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_dot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (front_valid),
        .cross_set (cross_set),
        .out_valid (dot_valid),
        .mag_b     (mag_b),
        .mag_c     (mag_c),
        .den       (den),
        .tag_b     (dtag_b),
        .tag_c     (dtag_c)
    );

    // weight b lane
    bw_div #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_div_b (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dot_valid),
        .mag       (mag_b),
        .den       (den),
        .tag_in    (dtag_b),
        .out_valid (div_b_valid),
        .quot      (quot_b),
        .tag_out   (tag_b)
    );

    // weight c lane, runs in lock step with lane b
    bw_div #(
        .WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
    ) u_div_c (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (dot_valid),
        .mag       (mag_c),
        .den       (den),
        .tag_in    (dtag_c),
        .out_valid (div_c_valid),
        .quot      (quot_c),
        .tag_out   (tag_c)
    );

    // restore the sign of each rounded quotient
    always_comb
    begin
        wb_next = tag_b.neg ? -sq_t'(quot_b) : sq_t'(quot_b);
        wc_next = tag_c.neg ? -sq_t'(quot_c) : sq_t'(quot_c);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wb_reg    <= wb_next;
            wc_reg    <= wc_next;
            degen_reg <= tag_b.degen;
        end
    end

    // weight a from the rounded quotients, then saturation of all three
    always_comb
    begin
        wa_sum = ONE - wsum_t'(wb_reg) - wsum_t'(wc_reg);
        ca     = clip_weight(wa_sum);
        cb     = clip_weight(wsum_t'(wb_reg));
        cc     = clip_weight(wsum_t'(wc_reg));
        if (degen_reg)
        begin
            // flat triangle: all weights zero, no clipping reported
            weights_next.weight_a   = '0;
            weights_next.weight_b   = '0;
            weights_next.weight_c   = '0;
            weights_next.degenerate = 1'b1;
            weights_next.saturated  = 1'b0;
        end
        else
        begin
            weights_next.weight_a   = ca.w;
            weights_next.weight_b   = cb.w;
            weights_next.weight_c   = cc.w;
            weights_next.degenerate = 1'b0;
            weights_next.saturated  = ca.sat || cb.sat || cc.sat;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
            weights_reg <= weights_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t1_valid_reg      <= 1'b0;
            weights_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            t1_valid_reg      <= div_b_valid;
            weights_valid_reg <= t1_valid_reg;
        end
    end

    assign weights_valid = weights_valid_reg;
    assign weights       = weights_reg;

    // the two divider lanes carry the same word at the same time
    lane_lock_a: assert property (@(posedge clk) disable iff (!rst_n)
        (div_b_valid == div_c_valid) && (!div_b_valid || (tag_b.degen == tag_c.degen)))
        else $error("divider lanes out of step");

    // a flat triangle gives zero weights and no clip flag
    degen_zero_a: assert property (@(posedge clk) disable iff (!rst_n)
        weights_valid && weights.degenerate |->
            (weights.weight_a == '0) && (weights.weight_b == '0)
            && (weights.weight_c == '0) && !weights.saturated)
        else $error("degenerate word with nonzero weights");

    // a clip flag means some weight sits at a range limit
    sat_limit_a: assert property (@(posedge clk) disable iff (!rst_n)
        weights_valid && weights.saturated |->
            (weights.weight_a == weight_t'(W_MAX)) || (weights.weight_a == weight_t'(W_MIN))
            || (weights.weight_b == weight_t'(W_MAX)) || (weights.weight_b == weight_t'(W_MIN))
            || (weights.weight_c == weight_t'(W_MAX)) || (weights.weight_c == weight_t'(W_MIN)))
        else $error("saturated word with no weight at a limit");

    // a stall freezes the signed quotient stage
    stall_hold_a: assert property (@(posedge clk) disable iff (!rst_n)
        !query_ready |=> $stable(t1_valid_reg))
        else $error("pipeline moved during a stall");

endmodule
